// ----- rtl/core/apb_pkg.sv -----
// Package for the articulation point and bridge finder.
// Constants shared by the RAM-based core; no dependencies.
`timescale 1ns / 1ps
package apb_pkg;
  localparam logic [1:0] KIND_CUT    = 2'd0;
  localparam logic [1:0] KIND_BRIDGE = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;
endpackage

// ----- rtl/core/apb_if.sv -----
// Valid/ready channel interface for the articulation point and bridge finder.
// Depends on nothing; the payload width is a parameter.
`timescale 1ns / 1ps
interface apb_if #(parameter int unsigned W = 8) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/apb_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the neighbor lists of the articulation point and bridge finder.
`timescale 1ns / 1ps
module apb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- rtl/core/articulation_points_and_bridges.sv -----
// Articulation points and bridges of an undirected graph, found by a depth-first walk.
// Edges load into half-edge lists held in RAM. An accepted edge stores two half edges (its
// second half edge is linked in the following cycle, with the input held off). After the
// item flagged last_edge the walk runs: each root candidate is tried in turn, each half
// edge examined passes through step, registered RAM read and evaluate, and each retreat
// folds a child into its parent. The report then scans the cut flags vertex by vertex
// and sends one bridge per cycle while the output is not stalled, closing with the
// end item. The input is not accepted during the walk and the report.
`timescale 1ns / 1ps
module articulation_points_and_bridges
  import apb_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 32,
  parameter int unsigned MAX_EDGES    = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [5:0] cfg_wdata_i,
  apb_if.sink       in_i,
  apb_if.source     out_o
);
  localparam int unsigned HE = 2 * MAX_EDGES;
  localparam int unsigned LW = 8;
  localparam int unsigned AW = $clog2(HE);
  localparam logic [LW-1:0] NIL = '1;
  localparam int unsigned VD = 32;
  localparam int unsigned SD = MAX_VERTICES;
  localparam int unsigned SW = $clog2(SD);
  localparam int unsigned BD = MAX_VERTICES;
  localparam int unsigned BW = $clog2(BD + 1);
  localparam int unsigned BAW = $clog2(BD);

  typedef enum logic [7:0] {
    S_LOAD = 8'b00000001, S_LINK = 8'b00000010, S_ROOT = 8'b00000100,
    S_STEP = 8'b00001000, S_READ = 8'b00010000, S_EVAL = 8'b00100000,
    S_CUTS = 8'b01000000, S_BRG  = 8'b10000000
  } state_e;

  // vertices 1..32 map onto five index bits, 32 landing on the otherwise unused slot 0
  function automatic logic [4:0] vi(logic [5:0] v);
    return v[4:0];
  endfunction

  state_e st_q;
  logic [5:0] vcnt_q;
  logic [LW-1:0] head_q [VD];
  logic [LW-1:0] tail_q [VD];
  logic [LW-1:0] hcnt_q;
  logic drop_q;
  logic [5:0] disc_q [VD];
  logic [5:0] low_q  [VD];
  logic cut_q [VD];
  logic [5:0] fv_q [SD], fp_q [SD];
  logic [LW-1:0] fl_q [SD];
  logic [5:0] fc_q [SD];
  logic [5:0] sp_q, clk_q, root_q;
  logic [5:0] b0_q [BD], b1_q [BD];
  logic [BW-1:0] bc_q, bi_q;
  logic [5:0] pa_q, pb_q, cv_q;
  logic last_q;
  logic out_v_q;
  logic [15:0] out_d_q;

  // Two RAMs hold neighbor and next-link per half edge; one write port each.
  logic nb_we, nl_we;
  logic [AW-1:0] nb_wa, nl_wa, rd_a;
  logic [5:0] nb_wd, nb_rd;
  logic [LW-1:0] nl_wd, nl_rd;
  apb_ram #(.WIDTH(6), .DEPTH(HE)) u_nb (.clk_i, .we_i(nb_we), .waddr_i(nb_wa),
    .wdata_i(nb_wd), .raddr_i(rd_a), .rdata_o(nb_rd));
  apb_ram #(.WIDTH(LW), .DEPTH(HE)) u_nl (.clk_i, .we_i(nl_we), .waddr_i(nl_wa),
    .wdata_i(nl_wd), .raddr_i(rd_a), .rdata_o(nl_rd));

  logic [5:0] n_eff;
  assign n_eff = (vcnt_q > 6'(MAX_VERTICES)) ? 6'(MAX_VERTICES) : vcnt_q;

  logic [5:0] a_i, b_i;
  logic he_i, le_i;
  assign a_i = in_i.data[5:0];
  assign b_i = in_i.data[11:6];
  assign he_i = in_i.data[12];
  assign le_i = in_i.data[13];
  assign in_i.ready = (st_q == S_LOAD);
  assign out_o.valid = out_v_q;
  assign out_o.data = out_d_q;
  logic out_free;
  assign out_free = !out_v_q || out_o.ready;

  logic emit;
  assign emit = out_free && ((st_q == S_CUTS && cv_q <= n_eff && cut_q[vi(cv_q)]) ||
                             st_q == S_BRG);

  logic [5:0] top, tv, tp;
  logic [SW-1:0] ti;
  logic [LW-1:0] tl;
  assign top = sp_q - 6'd1;
  assign ti = top[SW-1:0];
  assign tv = fv_q[ti];
  assign tp = fp_q[ti];
  assign tl = fl_q[ti];
  assign rd_a = tl[AW-1:0];

  logic ok_edge;
  assign ok_edge = a_i != 6'd0 && b_i != 6'd0 && a_i <= n_eff && b_i <= n_eff &&
                   (9'(hcnt_q) + 9'd2 <= 9'(HE));

  // Store the new half edge and hook it behind the current tail of its list.
  always_comb begin
    nb_we = 1'b0;
    nb_wa = hcnt_q[AW-1:0];
    nb_wd = b_i;
    nl_we = 1'b0;
    nl_wa = tail_q[vi(a_i)][AW-1:0];
    nl_wd = hcnt_q;
    if (st_q == S_LOAD && in_i.valid && he_i && ok_edge) begin
      nb_we = 1'b1;
      nl_we = (head_q[vi(a_i)] != NIL);
    end else if (st_q == S_LINK) begin
      nb_we = 1'b1;
      nb_wd = pa_q;
      nl_wa = tail_q[vi(pb_q)][AW-1:0];
      nl_we = (head_q[vi(pb_q)] != NIL);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_LOAD; vcnt_q <= 6'd32; hcnt_q <= '0; drop_q <= 1'b0;
      sp_q <= '0; clk_q <= '0; bc_q <= '0; bi_q <= '0; out_v_q <= 1'b0;
      out_d_q <= '0; root_q <= '0; cv_q <= '0; pa_q <= '0; pb_q <= '0;
      last_q <= 1'b0;
      for (int i = 0; i < VD; i++) begin
        head_q[i] <= NIL; tail_q[i] <= '0; cut_q[i] <= 1'b0;
        disc_q[i] <= '0; low_q[i] <= '0;
      end
      for (int i = 0; i < SD; i++) begin
        fv_q[i] <= '0; fp_q[i] <= '0; fl_q[i] <= NIL; fc_q[i] <= '0;
      end
      for (int i = 0; i < BD; i++) begin
        b0_q[i] <= '0; b1_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) vcnt_q <= cfg_wdata_i;
      if (emit) out_v_q <= 1'b1;
      else if (out_o.ready) out_v_q <= 1'b0;
      unique case (st_q)
        S_LOAD: begin
          if (in_i.valid) begin
            last_q <= le_i;
            if (he_i && ok_edge) begin
              if (head_q[vi(a_i)] == NIL) head_q[vi(a_i)] <= hcnt_q;
              tail_q[vi(a_i)] <= hcnt_q;
              hcnt_q <= hcnt_q + 8'd1;
              pa_q <= a_i; pb_q <= b_i;
              st_q <= S_LINK;
            end else begin
              if (he_i) drop_q <= 1'b1;
              if (le_i) begin
                for (int i = 0; i < VD; i++) begin
                  disc_q[i] <= '0; cut_q[i] <= 1'b0; end
                clk_q <= '0; bc_q <= '0; sp_q <= '0; root_q <= 6'd1; st_q <= S_ROOT;
              end
            end
          end
        end
        S_LINK: begin
          if (head_q[vi(pb_q)] == NIL) head_q[vi(pb_q)] <= hcnt_q;
          tail_q[vi(pb_q)] <= hcnt_q;
          hcnt_q <= hcnt_q + 8'd1;
          if (last_q) begin
            for (int i = 0; i < VD; i++) begin
              disc_q[i] <= '0; cut_q[i] <= 1'b0; end
            clk_q <= '0; bc_q <= '0; sp_q <= '0; root_q <= 6'd1; st_q <= S_ROOT;
          end else st_q <= S_LOAD;
        end
        S_ROOT: begin
          if (root_q > n_eff) begin cv_q <= 6'd1; st_q <= S_CUTS; end
          else begin
            if (disc_q[vi(root_q)] == 6'd0) begin
              disc_q[vi(root_q)] <= clk_q + 6'd1; low_q[vi(root_q)] <= clk_q + 6'd1;
              clk_q <= clk_q + 6'd1;
              fv_q[0] <= root_q; fp_q[0] <= '0; fl_q[0] <= head_q[vi(root_q)];
              fc_q[0] <= '0; sp_q <= 6'd1; st_q <= S_STEP;
            end
            root_q <= root_q + 6'd1;
          end
        end
        S_STEP: begin
          if (sp_q == 6'd0) st_q <= S_ROOT;
          else if (tl == NIL || tl >= LW'(HE)) begin
            // retreat: fold child into parent
            sp_q <= top;
            if (top != 6'd0) begin : ret
              logic [5:0] g, p, lu;
              g = top - 6'd1; p = fv_q[g[SW-1:0]]; lu = low_q[vi(tv)];
              if (lu < low_q[vi(p)]) low_q[vi(p)] <= lu;
              if (fp_q[g[SW-1:0]] == 6'd0 && fc_q[g[SW-1:0]] > 6'd1) cut_q[vi(p)] <= 1'b1;
              if (fp_q[g[SW-1:0]] != 6'd0 && lu >= disc_q[vi(p)]) cut_q[vi(p)] <= 1'b1;
              if (lu > disc_q[vi(p)] && bc_q < BW'(BD)) begin
                b0_q[bc_q[BAW-1:0]] <= (p < tv) ? p : tv;
                b1_q[bc_q[BAW-1:0]] <= (p < tv) ? tv : p;
                bc_q <= bc_q + BW'(1);
              end
            end
          end else st_q <= S_READ;
        end
        S_READ: st_q <= S_EVAL;
        S_EVAL: begin : ev
          logic [5:0] w;
          w = nb_rd;
          // the tail of a list has no successor; its link entry is not written while it is the tail
          fl_q[ti] <= (tl == tail_q[vi(tv)]) ? NIL : nl_rd;
          st_q <= S_STEP;
          if (!(w == tp || w == 6'd0 || w > 6'(MAX_VERTICES))) begin
            if (disc_q[vi(w)] == 6'd0) begin
              fc_q[ti] <= fc_q[ti] + 6'd1;
              if (sp_q < 6'(SD)) begin
                disc_q[vi(w)] <= clk_q + 6'd1; low_q[vi(w)] <= clk_q + 6'd1;
                clk_q <= clk_q + 6'd1;
                fv_q[sp_q[SW-1:0]] <= w; fp_q[sp_q[SW-1:0]] <= tv;
                fl_q[sp_q[SW-1:0]] <= head_q[vi(w)];
                fc_q[sp_q[SW-1:0]] <= '0; sp_q <= sp_q + 6'd1;
              end
            end else if (disc_q[vi(w)] < low_q[vi(tv)]) low_q[vi(tv)] <= disc_q[vi(w)];
          end
        end
        S_CUTS: begin
          if (out_free) begin
            if (cv_q > n_eff) begin bi_q <= '0; st_q <= S_BRG; end
            else begin
              if (cut_q[vi(cv_q)]) out_d_q <= {1'b0, drop_q, 6'd0, cv_q, KIND_CUT};
              cv_q <= cv_q + 6'd1;
            end
          end
        end
        S_BRG: begin
          if (out_free) begin
            if (bi_q < bc_q) begin
              out_d_q <= {1'b0, drop_q, b1_q[bi_q[BAW-1:0]], b0_q[bi_q[BAW-1:0]],
                          KIND_BRIDGE};
              bi_q <= bi_q + BW'(1);
            end else begin
              out_d_q <= {1'b1, drop_q, 6'd0, 6'd0, KIND_END};
              for (int i = 0; i < VD; i++) head_q[i] <= NIL;
              hcnt_q <= '0; drop_q <= 1'b0; st_q <= S_LOAD;
            end
          end
        end
        default: st_q <= S_LOAD;
      endcase
    end
  end
endmodule
